// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the keypad scan blocks, used by the key queue
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is asserted
`define KPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("keypad assertion failed");

// checked property, also checked during reset
`define KPD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("keypad assertion failed");

`else

`define KPD_ASSERT(lbl, clk, rst_n, prop)
`define KPD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/kpd_pkg.sv =====
// types, constants and key map for the keypad scan decoder with key queue
// no dependencies
package kpd_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = 7;
	localparam int SAMPLE_W    = 16;
	localparam int FILL_W      = 3;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [FILL_W-1:0]   fill_t;

	typedef enum logic {
		CMD_SCAN = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	localparam key_t NO_KEY = '0;

	// ascii per matrix position, index 4*row+col
	localparam key_t KEY_MAP [SAMPLE_W] = '{
		7'h44, 7'h23, 7'h30, 7'h2A,   // D # 0 *
		7'h43, 7'h39, 7'h38, 7'h37,   // C 9 8 7
		7'h42, 7'h36, 7'h35, 7'h34,   // B 6 5 4
		7'h41, 7'h33, 7'h32, 7'h31    // A 3 2 1
	};

	typedef struct packed {
		logic single;   // exactly one key pressed
		key_t key;      // ascii of that key, valid with single
	} scan_t;

	typedef struct packed {
		logic empty;
		logic full;
		key_t head;       // oldest stored key
		cnt_t count_nxt;  // fill count after this cycle's push or pop
	} fifo_stat_t;

	// result word, lowest field in the lowest bits
	typedef struct packed {
		logic [2:0] pad;
		fill_t      fill_level;
		logic       dropped;
		logic       pushed;
		logic       key_valid;
		key_t       key_char;
	} out_word_t;

endpackage

// ===== hw/rtl/kpd_decode.sv =====
// scan decode: single-press detect and ascii lookup of a 4x4 matrix sample
// depends on kpd_pkg
module kpd_decode (
	input  kpd_pkg::sample_t sample,
	output kpd_pkg::scan_t   scan
);
	import kpd_pkg::*;

	sample_t pressed;
	key_t    key_or;

	assign pressed = ~sample;

	// with one bit set the or of all mapped keys is that key
	always_comb begin
		key_or = NO_KEY;
		for (int b = 0; b < SAMPLE_W; b++) begin
			if (pressed[b]) begin
				key_or = key_or | KEY_MAP[b];
			end
		end
	end

	assign scan.single = (pressed != '0) && ((pressed & (pressed - sample_t'(1))) == '0);
	assign scan.key    = key_or;

endmodule

// ===== hw/rtl/kpd_fifo.sv =====
// key queue: register store with read and write pointers and fill count
// depends on kpd_pkg and assert_macros.svh
`include "assert_macros.svh"

module kpd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  logic                pop_en,
	input  kpd_pkg::key_t       push_data,
	output kpd_pkg::fifo_stat_t stat
);
	import kpd_pkg::*;

	key_t store_q [QUEUE_DEPTH];
	ptr_t rd_q;
	ptr_t wr_q;
	cnt_t count_q;

	function automatic ptr_t next_ptr(input ptr_t p);
		next_ptr = (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push_en) begin
			store_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_en) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop_en) begin
				rd_q <= next_ptr(rd_q);
			end
			count_q <= stat.count_nxt;
		end
	end

	always_comb begin
		stat.empty = (count_q == '0);
		stat.full  = (count_q == cnt_t'(QUEUE_DEPTH));
		stat.head  = store_q[rd_q];
		if (push_en && !pop_en) begin
			stat.count_nxt = count_q + cnt_t'(1);
		end else if (pop_en && !push_en) begin
			stat.count_nxt = count_q - cnt_t'(1);
		end else begin
			stat.count_nxt = count_q;
		end
	end

	`KPD_ASSERT(a_count_bound, clk, arst_n, count_q <= cnt_t'(QUEUE_DEPTH))
	`KPD_ASSERT(a_no_push_full, clk, arst_n, push_en |-> !stat.full)
	`KPD_ASSERT(a_no_pop_empty, clk, arst_n, pop_en |-> !stat.empty)
	`KPD_ASSERT(a_push_pop_excl, clk, arst_n, !(push_en && pop_en))
	`KPD_ASSERT(a_empty_ptrs, clk, arst_n, stat.empty |-> (rd_q == wr_q))

endmodule

// ===== hw/rtl/keypad_scan_decode_fifo_top.sv =====
// top level of the 4x4 keypad scan decoder with key queue
// depends on kpd_pkg, kpd_decode and kpd_fifo
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata = matrix_sample, tuser = cmd
// m_*      out  m_tvalid/m_tready    tdata = key_char, key_valid, pushed, dropped, fill_level
//
// one word accepted per cycle when the output side keeps up; a word passes the
// input register, then the result register, with decode and queue update between
// asynchronous reset clears valids, pointers, fill count and the last key;
// the key store itself is not cleared and is only read where the count covers it
// an output stall holds the result register and then the input register;
// s_tready follows m_tready in the same cycle so no word is lost or doubled
module keypad_scan_decode_fifo_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] matrix_sample
	input  logic        s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [6:0] key_char, [7] key_valid, [8] pushed,
	                               // [9] dropped, [12:10] fill_level, [15:13] zero
);
	import kpd_pkg::*;

	// input register
	logic       valid_s1;
	cmd_t       cmd_s1;
	sample_t    sample_s1;

	// result register
	logic       out_valid_q;
	out_word_t  out_q;

	// last accepted single key, NO_KEY after release or multi-press
	key_t       prev_key_q;
	key_t       prev_key_nxt;

	scan_t      scan;
	fifo_stat_t stat;

	logic       advance;
	logic       push_c;
	logic       pop_c;
	logic       dropped_c;
	logic       key_valid_c;
	key_t       key_char_c;
	out_word_t  out_nxt;

	// stage 1 moves into the result register when that is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1    <= cmd_t'(s_tuser);
			sample_s1 <= s_tdata;
		end
	end

	kpd_decode u_decode (
		.sample (sample_s1),
		.scan   (scan)
	);

	// item decision: pop the head unless empty, or push a new single key, dropped when full
	always_comb begin
		push_c       = 1'b0;
		pop_c        = 1'b0;
		dropped_c    = 1'b0;
		key_valid_c  = 1'b0;
		key_char_c   = NO_KEY;
		prev_key_nxt = prev_key_q;
		unique case (cmd_s1)
			CMD_POP: begin
				if (!stat.empty) begin
					pop_c       = 1'b1;
					key_valid_c = 1'b1;
					key_char_c  = stat.head;
				end
			end
			CMD_SCAN: begin
				if (scan.single) begin
					// held key does nothing; a new one is stored or dropped
					if (scan.key != prev_key_q) begin
						prev_key_nxt = scan.key;
						if (stat.full) begin
							dropped_c = 1'b1;
						end else begin
							push_c = 1'b1;
						end
					end
				end else begin
					// release or several keys
					prev_key_nxt = NO_KEY;
				end
			end
			default: begin
			end
		endcase
	end

	kpd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance && push_c),
		.pop_en    (advance && pop_c),
		.push_data (scan.key),
		.stat      (stat)
	);

	always_comb begin
		out_nxt.pad        = '0;
		out_nxt.fill_level = fill_t'(stat.count_nxt);
		out_nxt.dropped    = dropped_c;
		out_nxt.pushed     = push_c;
		out_nxt.key_valid  = key_valid_c;
		out_nxt.key_char   = key_char_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_key_q  <= NO_KEY;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				prev_key_q  <= prev_key_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== dv/keypad_scan_decode_fifo_top_test.sv =====
// self-checking test of the keypad scan decoder with key queue: directed table, then random words
// depends on kpd_pkg and keypad_scan_decode_fifo_top; results checked against a local predictor
`timescale 1ns / 100ps

module keypad_scan_decode_fifo_top_test;
	import kpd_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 1130;
	localparam int DRAIN_AT     = 700;    // random word index where the sender waits for all results

	// ascii per matrix position, position 0 in the top byte
	localparam logic [8*SAMPLE_W-1:0] KEY_CHARS = "D#0*C987B654A321";

	// one row of the directed table; want is used only where typed is set
	typedef struct packed {
		cmd_t      cmd;
		sample_t   sample;
		logic      typed;
		out_word_t want;
	} stim_row_t;

	// want pattern order: pad, fill_level, dropped, pushed, key_valid, key_char
	localparam int DIRECTED_N = 22;
	localparam stim_row_t DIRECTED [DIRECTED_N] = '{
		'{CMD_POP,  16'h0000, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 7'h00}}, // pop when empty
		'{CMD_SCAN, 16'hFFFF, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 7'h00}}, // release
		'{CMD_SCAN, 16'h0000, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b0, 7'h00}}, // every key down
		'{CMD_SCAN, 16'hFFFE, 1'b1, '{3'd0, 3'd1, 1'b0, 1'b1, 1'b0, 7'h00}}, // 'D' stored
		'{CMD_SCAN, 16'hFFFE, 1'b0, '0},                                     // 'D' held
		'{CMD_SCAN, 16'h7FFF, 1'b0, '0},                                     // '1', last position
		'{CMD_SCAN, 16'hFFFF, 1'b0, '0},                                     // release
		'{CMD_SCAN, 16'h7FFF, 1'b0, '0},                                     // '1' again after release
		'{CMD_SCAN, 16'hFFFC, 1'b0, '0},                                     // two keys down
		'{CMD_SCAN, 16'hFFDF, 1'b0, '0},                                     // '9', queue now full
		'{CMD_SCAN, 16'hFBFF, 1'b1, '{3'd0, 3'd4, 1'b1, 1'b0, 1'b0, 7'h00}}, // '5' lost, full
		'{CMD_SCAN, 16'hFBFF, 1'b0, '0},                                     // '5' held, no new flag
		'{CMD_POP,  16'hFFFF, 1'b1, '{3'd0, 3'd3, 1'b0, 1'b0, 1'b1, 7'h44}}, // oldest is 'D'
		'{CMD_POP,  16'h0000, 1'b0, '0},
		'{CMD_POP,  16'hA5A5, 1'b0, '0},
		'{CMD_POP,  16'h5A5A, 1'b0, '0},
		'{CMD_POP,  16'hFFFF, 1'b0, '0},                                     // empty again
		'{CMD_SCAN, 16'hFFF7, 1'b0, '0},                                     // '*'
		'{CMD_SCAN, 16'hEFFF, 1'b0, '0},                                     // 'A'
		'{CMD_SCAN, 16'h5555, 1'b0, '0},                                     // many keys down
		'{CMD_POP,  16'h1234, 1'b0, '0},
		'{CMD_POP,  16'hEDCB, 1'b0, '0}
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    s_tvalid;
	logic    s_tready;
	logic    [15:0] s_tdata;   // [15:0] matrix_sample
	logic    s_tuser;          // [0] cmd
	logic    m_tvalid;
	logic    m_tready;
	logic    [15:0] m_tdata;   // [6:0] key_char, [7] key_valid, [8] pushed, [9] dropped,
	                           // [12:10] fill_level, [15:13] zero

	// predictor copy of the key queue and the last accepted key
	key_t      held_keys [QUEUE_DEPTH];
	ptr_t      head_idx   = '0;
	ptr_t      tail_idx   = '0;
	int        held_count = 0;
	key_t      last_key   = NO_KEY;

	out_word_t expected_key_words [$];
	out_word_t got_word;
	out_word_t want_word;
	int        errors      = 0;
	int        cycle_count = 0;

	keypad_scan_decode_fifo_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result word for one accepted input word; advances the predictor state
	function automatic out_word_t predict_key_word(cmd_t cmd, sample_t sample);
		out_word_t  w;
		sample_t    pressed;
		int         n_pressed;
		int         first_pos;
		logic [6:0] bit_lo;
		key_t       key;
		w         = '0;
		pressed   = ~sample;
		n_pressed = 0;
		first_pos = -1;
		if (cmd == CMD_POP) begin
			// empty pop leaves everything as it is
			if (held_count > 0) begin
				w.key_char  = held_keys[head_idx];
				w.key_valid = 1'b1;
				head_idx    = (head_idx == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : head_idx + ptr_t'(1);
				held_count--;
			end
		end else begin
			// first pressed position by row, then by column
			for (int b = 0; b < SAMPLE_W; b++) begin
				if (pressed[b]) begin
					if (first_pos < 0)
						first_pos = b;
					n_pressed++;
				end
			end
			if (n_pressed == 1) begin
				bit_lo = 7'(8 * (SAMPLE_W - 1 - first_pos));
				key    = KEY_CHARS[bit_lo +: KEY_W];
				if (key != last_key) begin
					if (held_count < QUEUE_DEPTH) begin
						held_keys[tail_idx] = key;
						tail_idx = (tail_idx == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : tail_idx + ptr_t'(1);
						held_count++;
						w.pushed = 1'b1;
					end else begin
						// lost key still becomes the last key, so holding it stays quiet
						w.dropped = 1'b1;
					end
					last_key = key;
				end
			end else begin
				// release or several keys down forget the last key
				last_key = NO_KEY;
			end
		end
		w.fill_level = fill_t'(held_count);
		return w;
	endfunction

	// offer one word from the falling edge and hold it until accepted
	task automatic send_word(cmd_t cmd, sample_t sample, logic typed, out_word_t want);
		out_word_t predicted;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= sample;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_key_word(cmd, sample);
		expected_key_words.push_back(typed ? want : predicted);
	endtask

	// sender gap: s_tvalid low for the length given by n
	task automatic hold_off_sender(int n);
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// stop offering until every expected result word has come back
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_key_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// result side: compare every accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_key_words.size() == 0) begin
				$error("result word %0h with nothing expected", m_tdata);
				errors++;
			end else begin
				got_word  = m_tdata;
				want_word = expected_key_words.pop_front();
				check_field("key_char",   16'(want_word.key_char),   16'(got_word.key_char));
				check_field("key_valid",  16'(want_word.key_valid),  16'(got_word.key_valid));
				check_field("pushed",     16'(want_word.pushed),     16'(got_word.pushed));
				check_field("dropped",    16'(want_word.dropped),    16'(got_word.dropped));
				check_field("fill_level", 16'(want_word.fill_level), 16'(got_word.fill_level));
				check_field("pad",        16'(want_word.pad),        16'(got_word.pad));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("keypad_scan_decode_fifo_top_test: FAIL");
			$finish;
		end
	end

	// receiver: stretches of random length, each with its own stall pattern,
	// plus a long hold-off now and then so the block backs up into s_tready
	initial begin : rx_side
		int rx_cycles;
		int stretch;
		int mode;
		int next_hold;
		m_tready  = 1'b0;
		rx_cycles = 0;
		next_hold = 400;
		forever begin
			if (rx_cycles >= next_hold) begin
				repeat (300) begin
					@(negedge clk);
					m_tready <= 1'b0;
					rx_cycles++;
				end
				next_hold = rx_cycles + 1600;
			end
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(8, 80);
			repeat (stretch) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;                          // full speed
					1: m_tready <= 1'($urandom_range(0, 1));      // coin flip
					2: m_tready <= ($urandom_range(0, 7) != 0);   // rare stalls
					default: m_tready <= rx_cycles[0];            // alternating
				endcase
				rx_cycles++;
			end
		end
	end

	// sender: reset, directed table, then bursts of random words
	initial begin : tx_side
		int         burst_left;
		int         kind;
		int         pos;
		int         last_pos;
		logic [3:0] p;
		logic [3:0] q;
		int         pop_pct;
		cmd_t       cmd;
		sample_t    sample;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		arst_n     = 1'b0;
		burst_left = 0;
		last_pos   = -1;
		pop_pct    = 45;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIRECTED_N; k++)
			send_word(DIRECTED[k].cmd, DIRECTED[k].sample, DIRECTED[k].typed, DIRECTED[k].want);
		wait_for_results();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == DRAIN_AT)
				wait_for_results();
			// alternate phases that fill the queue and phases that drain it
			if (i % 60 == 0)
				pop_pct = ($urandom_range(0, 1) != 0) ? 10 : 45;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				hold_off_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
			end
			burst_left--;

			cmd    = CMD_SCAN;
			sample = '1;
			if ($urandom_range(0, 99) < pop_pct) begin
				// pop carries a random sample that must be ignored
				cmd    = CMD_POP;
				sample = sample_t'($urandom);
			end else begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					// single key, often the same one held
					if (last_pos >= 0 && $urandom_range(0, 2) == 0)
						pos = last_pos;
					else
						pos = $urandom_range(0, SAMPLE_W - 1);
					sample   = ~(sample_t'(1) << pos);
					last_pos = pos;
				end else if (kind < 75) begin
					sample = '1;
				end else if (kind < 90) begin
					// at least two keys down, second position wraps around the matrix
					sample    = sample_t'($urandom);
					p         = 4'($urandom_range(0, SAMPLE_W - 1));
					q         = p + 4'($urandom_range(1, SAMPLE_W - 1));
					sample[p] = 1'b0;
					sample[q] = 1'b0;
				end else begin
					sample = sample_t'($urandom);
				end
			end
			send_word(cmd, sample, 1'b0, '0);
		end

		wait_for_results();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("keypad_scan_decode_fifo_top_test: PASS");
		else
			$display("keypad_scan_decode_fifo_top_test: FAIL");
		$finish;
	end

endmodule
